[hdl/bre_pkg.sv]
// ----------------------------------------------------------------------------
// bre_pkg
// shared types and constants for the bitmap range all-equal check
// ----------------------------------------------------------------------------
package bre_pkg;

  localparam int WORD_W      = 32;
  localparam int WIDX_W      = 6;   // word index field of a write
  localparam int BIT_W       = 12;  // bit index, length and size width
  localparam int OFF_W       = 5;   // bit position inside a word
  localparam int WORD_NUM_W  = BIT_W - OFF_W;  // word number taken from a bit index
  localparam int MAX_ADDR_W  = 12;  // enough for the deepest store

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [WIDX_W-1:0]   word_index;
    logic [WORD_W-1:0]   word_data;
    logic [BIT_W-1:0]    start_bit;
    logic [BIT_W-1:0]    range_length;
    logic                want_set;
  } item_t;

  typedef struct packed {
    logic answer;
    logic refused;
  } result_t;

  // store port request from the sequencer
  typedef struct packed {
    logic                  wr_en;
    logic [MAX_ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]     wr_data;
    logic                  rd_en;
    logic [MAX_ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // result handoff to the output register
  typedef struct packed {
    logic    load;
    result_t result;
  } res_xfer_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } ctrl_status_t;

  // bits at and above the first position
  function automatic logic [WORD_W-1:0] lo_mask(input logic [OFF_W-1:0] s);
    return {WORD_W{1'b1}} << s;
  endfunction

  // bits at and below the last position
  function automatic logic [WORD_W-1:0] hi_mask(input logic [OFF_W-1:0] e);
    return {WORD_W{1'b1}} >> (5'd31 - e);
  endfunction

endpackage

[hdl/bre_store.sv]
// ----------------------------------------------------------------------------
// bre_store
// bitmap word memory, one write and one registered read port
// ----------------------------------------------------------------------------
module bre_store
  import bre_pkg::*;
#(
  parameter int BITMAP_WORDS = 64
) (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [WORD_W-1:0] rd_data
);

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  logic [WORD_W-1:0] mem [BITMAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

[hdl/bre_ctrl.sv]
// ----------------------------------------------------------------------------
// bre_ctrl
// sequencer: clearing pass, word writes, range checks and word walk
// ----------------------------------------------------------------------------
module bre_ctrl
  import bre_pkg::*;
#(
  parameter int BITMAP_WORDS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [BIT_W-1:0]  size_bits,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  input  logic              out_free,
  output mem_req_t          req,
  input  logic [WORD_W-1:0] rd_data,
  output res_xfer_t         res,
  output ctrl_status_t      sts
);

  localparam int AW  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int CAP = BITMAP_WORDS * 32;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                state;
  logic [AW-1:0]         clr_addr;
  logic [WORD_NUM_W-1:0] cur_word;
  logic [WORD_NUM_W-1:0] first_word;
  logic [WORD_NUM_W-1:0] last_word;
  logic [WORD_NUM_W-1:0] chk_word;
  logic [OFF_W-1:0]      start_off;
  logic [OFF_W-1:0]      end_off;
  logic                  want;
  logic                  issuing;
  logic                  chk_valid;
  logic                  ok;
  result_t               hold;

  logic                  accept;
  logic                  idx_in_range;
  logic [BIT_W-1:0]      usable;
  logic [BIT_W:0]        range_end;
  logic [BIT_W-1:0]      last_bit;
  logic                  refuse;
  logic [WORD_W-1:0]     mask;
  logic                  mismatch;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);

  assign idx_in_range = (32'(item.word_index) < BITMAP_WORDS);
  assign usable       = (32'(size_bits) < CAP) ? size_bits : BIT_W'(CAP);
  assign range_end    = {1'b0, item.start_bit} + {1'b0, item.range_length};
  assign last_bit     = range_end[BIT_W-1:0] - BIT_W'(1);
  assign refuse       = (item.start_bit >= usable) || (item.range_length == '0) ||
                        (range_end > {1'b0, usable});

  always_comb begin
    mask = {WORD_W{1'b1}};
    if (chk_word == first_word) begin
      mask = mask & lo_mask(start_off);
    end
    if (chk_word == last_word) begin
      mask = mask & hi_mask(end_off);
    end
  end

  // a bit differs from the wanted value
  assign mismatch = |((rd_data ^ {WORD_W{want}}) & mask);

  always_comb begin
    req.wr_en   = (state == S_CLEAR) ||
                  (accept && (item.operation == OP_WRITE) && idx_in_range);
    req.wr_addr = (state == S_CLEAR) ? MAX_ADDR_W'(clr_addr) : MAX_ADDR_W'(item.word_index);
    req.wr_data = (state == S_CLEAR) ? '0 : item.word_data;
    req.rd_en   = (state == S_WALK) && issuing;
    req.rd_addr = MAX_ADDR_W'(cur_word);
  end

  assign res.load   = (state == S_DONE) && out_free;
  assign res.result = hold;

  assign sts.clearing = (state == S_CLEAR);
  assign sts.busy     = (state == S_WALK) || (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      issuing   <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(BITMAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
          clr_addr <= clr_addr + AW'(1);
        end
        S_IDLE: begin
          if (accept) begin
            if (item.operation == OP_WRITE) begin
              hold  <= '{answer: 1'b0, refused: 1'b0};
              state <= S_DONE;
            end else if (refuse) begin
              hold  <= '{answer: 1'b0, refused: 1'b1};
              state <= S_DONE;
            end else begin
              first_word <= item.start_bit[BIT_W-1:OFF_W];
              cur_word   <= item.start_bit[BIT_W-1:OFF_W];
              last_word  <= last_bit[BIT_W-1:OFF_W];
              start_off  <= item.start_bit[OFF_W-1:0];
              end_off    <= last_bit[OFF_W-1:0];
              want       <= item.want_set;
              ok         <= 1'b1;
              issuing    <= 1'b1;
              chk_valid  <= 1'b0;
              state      <= S_WALK;
            end
          end
        end
        S_WALK: begin
          // issuing is already low when the last word is checked
          chk_valid <= issuing;
          chk_word  <= cur_word;
          if (issuing) begin
            if (cur_word == last_word) begin
              issuing <= 1'b0;
            end else begin
              cur_word <= cur_word + WORD_NUM_W'(1);
            end
          end
          if (chk_valid) begin
            ok <= ok && !mismatch;
            if (chk_word == last_word) begin
              hold  <= '{answer: ok && !mismatch, refused: 1'b0};
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/bitmap_range_all_equal_check.sv]
// ----------------------------------------------------------------------------
// bitmap_range_all_equal_check
// bitmap word store with a range test for all bits set or all bits clear
// ----------------------------------------------------------------------------
//   channel   direction  handshake                  beat
//   item      in         item_valid / item_stall    item_t (write word or query)
//   result    out        result_valid / result_stall result_t (answer, refused)
//   cfg       in         cfg_valid / cfg_ready      size_bits, 12 bits
//
// a write and a refused query go from idle straight to the done state; an accepted
// query first walks every 32-bit word the range spans;
// the walk reads one stored word per cycle through the single memory read port
// after reset a clearing pass zeroes the store, with item_stall high; cfg writes
// are taken throughout
// items are accepted while a finished result waits in the output register;
// a result that finds the output register full waits inside the sequencer
// ----------------------------------------------------------------------------
module bitmap_range_all_equal_check
  import bre_pkg::*;
#(
  parameter int BITMAP_WORDS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [BIT_W-1:0] cfg_data,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result
);

  logic [BIT_W-1:0]  size_bits;
  mem_req_t          req;
  logic [WORD_W-1:0] rd_data;
  res_xfer_t         res;
  ctrl_status_t      sts;
  logic              out_free;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_bits <= '0;
    end else if (cfg_valid) begin
      size_bits <= cfg_data;
    end
  end

  // output register can take a new beat when empty or draining
  assign out_free = !result_valid || !result_stall;

  bre_store #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  bre_ctrl #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .size_bits  (size_bits),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .out_free   (out_free),
    .req        (req),
    .rd_data    (rd_data),
    .res        (res),
    .sts        (sts)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      result <= res.result;
    end
  end

  // no item gets in during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    sts.clearing |-> item_stall)
    else $error("item accepted during clearing pass");

  // an accepted beat always leaves work pending
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (sts.busy || result_valid))
    else $error("accepted beat produced no pending work");

  // a result never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res.load |-> (!result_valid || !result_stall))
    else $error("output register overrun");

  // a refused query never answers true
  a_refuse_false: assert property (@(posedge clk) disable iff (rst)
    res.load && res.result.refused |-> !res.result.answer)
    else $error("refused query answered true");

endmodule
